// File: rtl/core/stsl_pkg.sv
// Shared types and constants for the sorted step-table lookup.
// No dependencies; used by every file of the block.
package stsl_pkg;

   // fixed field widths
   localparam int POS_W  = 32;
   localparam int TEMP_W = 13;
   localparam int IDX_W  = 10;
   localparam int CFG_W  = 11;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // request word
   typedef struct packed {
      logic              operation;
      logic [IDX_W-1:0]  entry_index;
      logic [POS_W-1:0]  position;
      logic [TEMP_W-1:0] entry_temperature;
   } stsl_req_type;

   // response word
   typedef struct packed {
      logic [TEMP_W-1:0] temperature;
      logic              has_value;
   } stsl_rsp_type;

   // table write port (address travels separately, its width follows depth)
   typedef struct packed {
      logic              en;
      logic [POS_W-1:0]  position;
      logic [TEMP_W-1:0] temperature;
   } stsl_tbl_wr_type;

endpackage

// File: rtl/core/stsl_table.sv
// Position and temperature table: one write port, one shared read address,
// registered read data. Depends on stsl_pkg.
module stsl_table
   import stsl_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                  clock,
   input  stsl_tbl_wr_type       wr,
   input  logic [AW-1:0]         wr_addr,
   input  logic [AW-1:0]         rd_addr,
   output logic [POS_W-1:0]      rd_position,
   output logic [TEMP_W-1:0]     rd_temperature
);

   logic [POS_W-1:0]  pos_mem  [DEPTH];
   logic [TEMP_W-1:0] temp_mem [DEPTH];
   logic [POS_W-1:0]  rd_pos_ff;
   logic [TEMP_W-1:0] rd_temp_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         pos_mem[wr_addr]  <= wr.position;
         temp_mem[wr_addr] <= wr.temperature;
      end
   end

   // read port, data registered and valid the cycle after the address
   always_ff @(posedge clock) begin
      rd_pos_ff  <= pos_mem[rd_addr];
      rd_temp_ff <= temp_mem[rd_addr];
   end

   assign rd_position    = rd_pos_ff;
   assign rd_temperature = rd_temp_ff;

endmodule

// File: rtl/core/sorted_table_step_lookup.sv
// Top level of the sorted step-table lookup: command port, register,
// search sequencer and shared comparator. Depends on stsl_pkg, stsl_table.
//
//   channel   ports                                 handshake
//   -------   -----------------------------------   ---------------------------
//   request   start, busy, req_word                 taken when start && !busy
//   response  rsp_strobe, rsp_word                  one cycle, cannot be held
//   config    csr_write_enable, csr_write_data      taken when write enable high
//
// A write word gives no response; busy stays low.
// A query on an empty table answers in the cycle after it is taken.
// Otherwise a query keeps busy high for up to 2 boundary probes, up to
// floor(log2(n)) + 1 search probes and at most one fetch. The single
// table read port takes one probe per cycle. Reset clears the register
// and the sequencer only.
module sorted_table_step_lookup
   import stsl_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  stsl_req_type       req_word,
   output logic               rsp_strobe,
   output stsl_rsp_type       rsp_word,
   input  logic               csr_write_enable,
   input  logic [CFG_W-1:0]   csr_write_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SEARCH,
      ST_FETCH
   } state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   count_ff;
   logic [POS_W-1:0]   query_ff, query_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [CW-1:0]      mid_ff, mid_in;
   logic               strobe_ff, strobe_in;
   stsl_rsp_type       rsp_ff, rsp_in;
   logic [AW-1:0]      rd_addr;

   stsl_tbl_wr_type    tbl_wr;
   logic [AW-1:0]      wr_addr;
   logic [POS_W-1:0]   rd_position;
   logic [TEMP_W-1:0]  rd_temperature;

   logic [31:0]        count32, n32, widx32;
   logic [CW-1:0]      n_ent, n_m1;
   logic               accept;
   logic [POS_W:0]     diff;
   logic               probe_lt, probe_eq;
   logic [CW-1:0]      lo_n, hi_n, mid_n, pick;

   // entries searched, clamped to the table depth
   assign count32 = 32'(count_ff);
   assign n32     = (count32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : count32;
   assign n_ent   = n32[CW-1:0];
   assign n_m1    = n_ent - CW'(1);

   assign accept  = start && !busy;
   assign busy    = (state_ff != ST_IDLE);

   // table write port
   assign widx32        = 32'(req_word.entry_index);
   assign wr_addr       = widx32[AW-1:0];
   assign tbl_wr.en     = accept && (req_word.operation == OP_WRITE)
                          && (widx32 < 32'(TABLE_DEPTH));
   assign tbl_wr.position    = req_word.position;
   assign tbl_wr.temperature = req_word.entry_temperature;

   stsl_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock          (clock),
      .wr             (tbl_wr),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .rd_position    (rd_position),
      .rd_temperature (rd_temperature)
   );

   // shared comparator: probed entry against the query
   assign diff     = {1'b0, rd_position} - {1'b0, query_ff};
   assign probe_lt = diff[POS_W];
   assign probe_eq = (diff[POS_W-1:0] == '0);

   // search step: halve the range around the probe
   always_comb begin
      if (probe_lt) begin
         lo_n = mid_ff + CW'(1);
         hi_n = hi_ff;
      end else begin
         lo_n = lo_ff;
         hi_n = mid_ff;
      end
      mid_n = lo_n + ((hi_n - lo_n) >> 1);
      pick  = (lo_n < n_ent) ? lo_n : n_m1;
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      query_in  = query_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      rd_addr   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.operation == OP_QUERY)) begin
               query_in = req_word.position;
               if (n_ent == '0) begin
                  strobe_in = 1'b1;
                  rsp_in    = '0;
               end else begin
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            // query at or below the first entry
            if (!probe_lt) begin
               strobe_in          = 1'b1;
               rsp_in.temperature = rd_temperature;
               rsp_in.has_value   = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               rd_addr  = n_m1[AW-1:0];
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            // query at or past the last entry
            if (probe_lt || probe_eq) begin
               strobe_in          = 1'b1;
               rsp_in.temperature = rd_temperature;
               rsp_in.has_value   = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               lo_in    = '0;
               hi_in    = n_ent;
               mid_in   = n_ent >> 1;
               rd_addr  = mid_in[AW-1:0];
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               mid_in  = mid_n;
               rd_addr = mid_n[AW-1:0];
            end else if (!probe_lt) begin
               // result is the entry just probed
               strobe_in          = 1'b1;
               rsp_in.temperature = rd_temperature;
               rsp_in.has_value   = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               rd_addr  = pick[AW-1:0];
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            strobe_in          = 1'b1;
            rsp_in.temperature = rd_temperature;
            rsp_in.has_value   = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      query_ff <= query_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      rsp_ff   <= rsp_in;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// File: rtl/core/stsl_checker.sv
// Port-level checks for the sorted step-table lookup, bound to the top
// level below. Depends on stsl_pkg.
module stsl_checker
   import stsl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  stsl_req_type       req_word,
   input  logic               rsp_strobe,
   input  stsl_rsp_type       rsp_word
);

   // an empty-table answer carries no temperature
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.has_value || (rsp_word.temperature == '0)))
      else $error("empty answer with nonzero temperature");

   // a write word never makes a response
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.operation == OP_WRITE)) |=> !rsp_strobe)
      else $error("response after a write word");

   // a query either answers at once or holds busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.operation == OP_QUERY)) |=> (busy || rsp_strobe))
      else $error("query dropped");

   // busy ends only with a response
   assert property (@(posedge clock) disable iff (reset)
      busy |=> (busy || rsp_strobe))
      else $error("busy ended without a response");

   // a response is shown only once the block is free
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

endmodule

bind sorted_table_step_lookup stsl_checker u_stsl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
